/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

/* rtl/nns_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest neighbour search package
// Sizes, types, operation codes and field conversions of the search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nns_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int DIMENSIONS  = 10;
  localparam int COORD_BITS  = 16;

  // Interface field widths, fixed by the stream format.
  localparam int MAX_DIMS    = 10;
  localparam int FIELD_W     = 16;
  localparam int IDX_FIELD_W = 8;
  localparam int DIST_W      = 36;
  localparam int IN_DATA_W   = MAX_DIMS * FIELD_W;
  localparam int RES_W       = IDX_FIELD_W + DIST_W + MAX_DIMS * FIELD_W;
  localparam int OUT_DATA_W  = ((RES_W + 7) / 8) * 8;
  localparam int NEAR_LSB    = IDX_FIELD_W + DIST_W;

  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
  localparam int POINT_W = DIMENSIONS * COORD_BITS;

  typedef logic [COORD_BITS-1:0]                  coord_t;
  typedef logic [DIMENSIONS-1:0][COORD_BITS-1:0]  point_t;
  typedef logic [DIST_W-1:0]                      dist_t;
  typedef logic [ADDR_W-1:0]                      addr_t;
  typedef logic [COUNT_W-1:0]                     count_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Travels beside each point read from the store through the distance pipe.
  typedef struct packed {
    logic  valid;
    logic  last;
    addr_t idx;
  } scan_tag_t;

  // A coordinate keeps the low COORD_BITS bits of its 16-bit field.
  function automatic coord_t field_to_coord(logic [FIELD_W-1:0] f);
    coord_t r;
    r = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      if (b < FIELD_W) begin
        r[b] = f[b];
      end
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] coord_to_field(coord_t c);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int b = 0; b < FIELD_W; b++) begin
      if (b < COORD_BITS) begin
        r[b] = c[b];
      end
    end
    return r;
  endfunction

  function automatic logic [IDX_FIELD_W-1:0] addr_to_field(addr_t a);
    logic [IDX_FIELD_W-1:0] r;
    r = '0;
    for (int b = 0; b < IDX_FIELD_W; b++) begin
      if (b < ADDR_W) begin
        r[b] = a[b];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/nns_point_ram.sv */
// ----------------------------------------------------------------------------
// Point store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nns_point_ram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire nns_pkg::addr_t             waddr_i,
  input  wire logic [nns_pkg::POINT_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire nns_pkg::addr_t             raddr_i,
  output      logic [nns_pkg::POINT_W-1:0] rdata_o
);

  logic [nns_pkg::POINT_W-1:0] mem_q [nns_pkg::STORE_DEPTH];
  logic [nns_pkg::POINT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/nns_dist_unit.sv */
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Four stages: absolute differences, squares, pair sums, total with clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module nns_dist_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire nns_pkg::scan_tag_t tag_i,
  input  wire nns_pkg::point_t    query_i,
  input  wire nns_pkg::point_t    point_i,
  output      nns_pkg::scan_tag_t tag_o,
  output      nns_pkg::dist_t     dist_o,
  output      nns_pkg::point_t    point_o
);

  localparam int MAG_W  = nns_pkg::COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int PAIR_W = SQ_W + 1;
  localparam int NPAIR  = (nns_pkg::DIMENSIONS + 1) / 2;
  localparam int SUM_W  = (SQ_W + 4 > nns_pkg::DIST_W + 1) ? SQ_W + 4 : nns_pkg::DIST_W + 1;
  localparam logic [SUM_W-1:0] SAT_LIMIT =
    {{(SUM_W - nns_pkg::DIST_W){1'b0}}, {nns_pkg::DIST_W{1'b1}}};

  nns_pkg::scan_tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  nns_pkg::point_t    pt1_q, pt2_q, pt3_q, pt4_q;

  logic signed [MAG_W-1:0] diff [nns_pkg::DIMENSIONS];
  logic [MAG_W-1:0]  mag_d [nns_pkg::DIMENSIONS];
  logic [MAG_W-1:0]  mag_q [nns_pkg::DIMENSIONS];
  logic [SQ_W-1:0]   sq_d  [nns_pkg::DIMENSIONS];
  logic [SQ_W-1:0]   sq_q  [nns_pkg::DIMENSIONS];
  logic [PAIR_W-1:0] pair_d [NPAIR];
  logic [PAIR_W-1:0] pair_q [NPAIR];
  logic [SUM_W-1:0]  sum;
  nns_pkg::dist_t    dist_d, dist_q;

  always_comb begin
    for (int d = 0; d < nns_pkg::DIMENSIONS; d++) begin
      diff[d] = $signed({point_i[d][nns_pkg::COORD_BITS-1], point_i[d]})
              - $signed({query_i[d][nns_pkg::COORD_BITS-1], query_i[d]});
      mag_d[d] = diff[d][MAG_W-1] ? MAG_W'(-diff[d]) : MAG_W'(diff[d]);
    end
  end

  always_comb begin
    for (int d = 0; d < nns_pkg::DIMENSIONS; d++) begin
      sq_d[d] = mag_q[d] * mag_q[d];
    end
  end

  // An odd dimension count leaves the last pair with a single square.
  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      pair_d[k] = {1'b0, sq_q[2*k]};
      if (2*k + 1 < nns_pkg::DIMENSIONS) begin
        pair_d[k] = pair_d[k] + {1'b0, sq_q[2*k+1]};
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NPAIR; k++) begin
      sum = sum + SUM_W'(pair_q[k]);
    end
    dist_d = (sum > SAT_LIMIT) ? {nns_pkg::DIST_W{1'b1}} : sum[nns_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pt1_q  <= point_i;
    pt2_q  <= pt1_q;
    pt3_q  <= pt2_q;
    pt4_q  <= pt3_q;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    pair_q <= pair_d;
    dist_q <= dist_d;
  end

  assign tag_o   = tag4_q;
  assign dist_o  = dist_q;
  assign point_o = pt4_q;

endmodule

`default_nettype wire

/* rtl/nearest_neighbour_search.sv */
// ----------------------------------------------------------------------------
// Nearest neighbour search
// Brute-force search for the stored point closest to a query point.
//
//   channel  dir  tdata                                    tuser
//   s_axis   in   coord_0..coord_9, 16 bits each           operation
//   m_axis   out  nearest_index, best_dist_sq, near_0..9   -
//
// A clear or an append leaves the block ready for the next request. A query reads
// the point store once per stored point, one entry a cycle, passes each entry
// through the four-stage distance pipe and loads the nearest one into the output
// register; a query on an empty set gives no result. The store has a single read port.
// Reset empties the set; the store itself is not cleared. While a query runs, or
// its result waits for a free output register, no request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_search (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  // coord_0 [15:0], coord_1 [31:16], ... coord_9 [159:144]
  input  wire logic [nns_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // operation [1:0]
  input  wire logic [1:0]                       s_axis_tuser_i,
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // nearest_index [7:0], best_dist_sq [43:8], near_0 [59:44], ...
  // near_9 [203:188], zero [207:204]
  output      logic [nns_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  state_e             state_q;
  nns_pkg::count_t    count_q;
  nns_pkg::addr_t     scan_addr_q;
  nns_pkg::point_t    query_q;
  nns_pkg::point_t    in_point;
  nns_pkg::scan_tag_t rd_tag_q;
  nns_pkg::scan_tag_t pipe_tag;
  nns_pkg::dist_t     pipe_dist;
  nns_pkg::point_t    pipe_point;
  logic [nns_pkg::POINT_W-1:0] rd_data;

  nns_pkg::dist_t     best_dist_q;
  nns_pkg::addr_t     best_idx_q;
  nns_pkg::point_t    best_pt_q;

  logic                            out_valid_q;
  logic [nns_pkg::OUT_DATA_W-1:0]  out_data_q;
  logic [nns_pkg::OUT_DATA_W-1:0]  res_data;

  logic            req_fire;
  logic            do_append;
  logic            scan_last;
  logic            take_new;
  logic            out_load;
  nns_pkg::addr_t  last_addr;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign do_append = req_fire && (s_axis_tuser_i == nns_pkg::OP_APPEND)
                     && (count_q < nns_pkg::COUNT_W'(nns_pkg::STORE_DEPTH));
  assign last_addr = nns_pkg::ADDR_W'(count_q - nns_pkg::COUNT_W'(1));
  assign scan_last = (scan_addr_q == last_addr);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    for (int d = 0; d < nns_pkg::DIMENSIONS; d++) begin
      in_point[d] = nns_pkg::field_to_coord(s_axis_tdata_i[d*nns_pkg::FIELD_W +: nns_pkg::FIELD_W]);
    end
  end

  nns_point_ram u_point_ram (
    .clk_i   (clk_i),
    .we_i    (do_append),
    .waddr_i (nns_pkg::ADDR_W'(count_q)),
    .wdata_i (in_point),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (scan_addr_q),
    .rdata_o (rd_data)
  );

  nns_dist_unit u_dist_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .query_i (query_q),
    .point_i (rd_data),
    .tag_o   (pipe_tag),
    .dist_o  (pipe_dist),
    .point_o (pipe_point)
  );

  // Running minimum; the first point always loads, later ones only when strictly closer.
  assign take_new = pipe_tag.valid
                    && ((pipe_tag.idx == '0) || (pipe_dist < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take_new) begin
      best_dist_q <= pipe_dist;
      best_idx_q  <= pipe_tag.idx;
      best_pt_q   <= pipe_point;
    end
    if (req_fire && (s_axis_tuser_i == nns_pkg::OP_QUERY)) begin
      query_q <= in_point;
    end
    if (out_load) begin
      out_data_q <= res_data;
    end
  end

  always_comb begin
    res_data = '0;
    res_data[nns_pkg::IDX_FIELD_W-1:0] = nns_pkg::addr_to_field(best_idx_q);
    res_data[nns_pkg::IDX_FIELD_W +: nns_pkg::DIST_W] = best_dist_q;
    for (int d = 0; d < nns_pkg::DIMENSIONS; d++) begin
      res_data[nns_pkg::NEAR_LSB + d*nns_pkg::FIELD_W +: nns_pkg::FIELD_W] =
        nns_pkg::coord_to_field(best_pt_q[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_addr_q <= '0;
      rd_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_tag_q.valid <= (state_q == ST_SCAN);
      rd_tag_q.last  <= scan_last;
      rd_tag_q.idx   <= scan_addr_q;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_append) begin
        count_q <= count_q + nns_pkg::COUNT_W'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (s_axis_tuser_i)
              nns_pkg::OP_CLEAR: begin
                count_q <= '0;
              end
              nns_pkg::OP_QUERY: begin
                if (count_q != '0) begin
                  scan_addr_q <= '0;
                  state_q     <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_addr_q <= scan_addr_q + nns_pkg::ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_tag.valid && pipe_tag.last) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/nns_checker.sv */
// ----------------------------------------------------------------------------
// Nearest neighbour search checker
// Port-level checks of the search block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nns_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [1:0]                     s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [nns_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic s_fire;
  logic short_req;

  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign short_req = (s_axis_tuser_i == nns_pkg::OP_CLEAR)
                     || (s_axis_tuser_i == nns_pkg::OP_APPEND);

  // A result that is not taken stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))

  // Clears and appends finish at once, so the input stays open after them.
  `ASSERT_CLK(a_short_req, clk_i, rst_ni, s_fire && short_req |=> s_axis_tready_o)

  // A new result only appears at the end of a scan, during which input is closed.
  `ASSERT_CLK(a_result_after_scan, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))

  // The pad bits above the last coordinate are zero whenever a result is offered.
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tdata_o[nns_pkg::OUT_DATA_W-1:nns_pkg::RES_W] != '0))

endmodule

bind nearest_neighbour_search nns_checker u_nns_checker (.*);

`default_nettype wire

/* test/tb_nearest_neighbour_search.sv */
// ----------------------------------------------------------------------------
// Nearest neighbour search testbench
// Streams clear, append and query requests into the search block and checks
// every result against a point store and a running-minimum search kept here.
// Both stream sides idle at random. The search block is never reset twice.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nearest_neighbour_search;

  localparam int               WATCHDOG_LIMIT = 4000;
  localparam int               SETTLE_CYCLES  = 300;
  localparam int               ITEM_TARGET    = 1050;
  localparam int               SHOWN_ERRORS   = 10;
  localparam logic [1:0]       OP_RESERVED    = 2'd3;
  localparam longint unsigned  DIST_CEIL      = (64'd1 << nns_pkg::DIST_W) - 64'd1;
  localparam logic [15:0]      COORD_MAX      = 16'h7fff;
  localparam logic [15:0]      COORD_MIN      = 16'h8000;

  typedef logic [nns_pkg::MAX_DIMS-1:0][nns_pkg::FIELD_W-1:0] point_vec_t;

  typedef struct packed {
    point_vec_t  coord;
    logic [1:0]  op;
  } nn_request_t;

  // Same order as the result bus: index in the lowest bits, then the
  // distance, then near_0 up to near_9.
  typedef struct packed {
    point_vec_t                       near;
    logic [nns_pkg::DIST_W-1:0]       dist_sq;
    logic [nns_pkg::IDX_FIELD_W-1:0]  index;
  } nn_result_t;

  typedef struct {
    nn_request_t  rq;
    bit           hold;
  } queued_request_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [nns_pkg::IN_DATA_W-1:0]   s_axis_tdata_i  = '0;
  logic [1:0]                      s_axis_tuser_i  = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [nns_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o;

  nearest_neighbour_search i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Stimulus and expectations.
  queued_request_t  pending_q[$];
  nn_result_t       expect_q[$];
  point_vec_t       gen_pts[$];
  point_vec_t       bank [nns_pkg::STORE_DEPTH];
  int unsigned      bank_count;
  int unsigned      bank_peak;

  queued_request_t  next_req;
  nn_request_t      req_now;
  nn_result_t       got, want;
  int               send_idle;
  int               recv_idle;
  int               n_items;
  int               n_accepted;
  int               n_results;
  int               n_queries;
  int               n_mismatch;
  int               quiet_cycles;
  longint unsigned  cycle_n;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // In every third span of the cycle count, both sides run without gaps.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_n / 1500) % 3 == 0) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned gap_sq(point_vec_t a, point_vec_t b);
    longint unsigned acc;
    longint          d;
    acc = 0;
    for (int k = 0; k < nns_pkg::DIMENSIONS; k++) begin
      d   = longint'($signed(a[k])) - longint'($signed(b[k]));
      acc = acc + longint'(d * d);
      if (acc > DIST_CEIL) begin
        acc = DIST_CEIL;
      end
    end
    return acc;
  endfunction

  // Updates the point store for one accepted request and queues the answer
  // of a query. The first strictly smaller distance wins, so ties keep the
  // lowest index.
  function automatic void apply_request(nn_request_t rq);
    nn_result_t       res;
    longint unsigned  best;
    longint unsigned  ds;
    int unsigned      best_i;
    case (rq.op)
      nns_pkg::OP_CLEAR: begin
        bank_count = 0;
      end
      nns_pkg::OP_APPEND: begin
        if (bank_count < nns_pkg::STORE_DEPTH) begin
          bank[bank_count] = rq.coord;
          bank_count++;
          if (bank_count > bank_peak) begin
            bank_peak = bank_count;
          end
        end
      end
      nns_pkg::OP_QUERY: begin
        n_queries++;
        if (bank_count > 0) begin
          best   = 0;
          best_i = 0;
          for (int unsigned i = 0; i < bank_count; i++) begin
            ds = gap_sq(rq.coord, bank[i]);
            if (i == 0 || ds < best) begin
              best   = ds;
              best_i = i;
            end
          end
          res         = '0;
          res.index   = best_i[nns_pkg::IDX_FIELD_W-1:0];
          res.dist_sq = best[nns_pkg::DIST_W-1:0];
          for (int k = 0; k < nns_pkg::DIMENSIONS; k++) begin
            res.near[k] = bank[best_i][k];
          end
          expect_q.insert(expect_q.size(), res);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    n_mismatch++;
    if (n_mismatch <= SHOWN_ERRORS) begin
      $display("mismatch in %s: expected 0x%0h, got 0x%0h (result %0d)",
               what, exp_v, act_v, n_results);
    end
  endfunction

  // Request side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      send_idle        = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_request(req_now);
        n_accepted++;
        send_idle = pick_gap();
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_idle > 0) begin
          send_idle--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].hold && expect_q.size() != 0)) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          next_req         = pending_q.pop_front();
          req_now          = next_req.rq;
          s_axis_tdata_i  <= req_now.coord;
          s_axis_tuser_i  <= req_now.op;
          s_axis_tvalid_i <= 1'b1;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_idle        = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = nn_result_t'(m_axis_tdata_o[nns_pkg::RES_W-1:0]);
        if (expect_q.size() == 0) begin
          note_mismatch("unexpected result index", '0, got.index);
        end else begin
          want = expect_q.pop_front();
          if (got.index !== want.index) begin
            note_mismatch("nearest_index", want.index, got.index);
          end
          if (got.dist_sq !== want.dist_sq) begin
            note_mismatch("best_dist_sq", want.dist_sq, got.dist_sq);
          end
          for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
            if (got.near[k] !== want.near[k]) begin
              note_mismatch($sformatf("near_%0d", k), want.near[k], got.near[k]);
            end
          end
        end
        if (m_axis_tdata_o[nns_pkg::OUT_DATA_W-1:nns_pkg::RES_W] !== '0) begin
          note_mismatch("padding bits", '0,
                        m_axis_tdata_o[nns_pkg::OUT_DATA_W-1:nns_pkg::RES_W]);
        end
        n_results++;
        recv_idle = pick_gap();
      end
      if (recv_idle > 0) begin
        recv_idle--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Ends the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    cycle_n++;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, expect_q.size());
      $display("FAIL nearest_neighbour_search");
      $finish;
    end
  end

  function automatic point_vec_t flat_point(logic [15:0] v);
    point_vec_t p;
    for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
      p[k] = v;
    end
    return p;
  endfunction

  function automatic point_vec_t rand_point();
    point_vec_t p;
    for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
      p[k] = 16'($urandom);
    end
    return p;
  endfunction

  // Coordinates close to the origin, so that distances stay small and close.
  function automatic point_vec_t near_origin_point();
    point_vec_t p;
    for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
      p[k] = 16'($urandom_range(0, 511) - 256);
    end
    return p;
  endfunction

  function automatic point_vec_t jitter(point_vec_t p);
    point_vec_t r;
    for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
      r[k] = p[k] + 16'($urandom_range(0, 6) - 3);
    end
    return r;
  endfunction

  function automatic point_vec_t any_stored();
    if (gen_pts.size() == 0) begin
      return rand_point();
    end
    return gen_pts[$urandom_range(0, gen_pts.size() - 1)];
  endfunction

  function automatic void queue_request(logic [1:0] op, point_vec_t pt, bit hold);
    queued_request_t e;
    e.rq.op    = op;
    e.rq.coord = pt;
    e.hold     = hold;
    pending_q.insert(pending_q.size(), e);
    n_items++;
    if (op == nns_pkg::OP_CLEAR) begin
      gen_pts.delete();
    end else if (op == nns_pkg::OP_APPEND && gen_pts.size() < nns_pkg::STORE_DEPTH) begin
      gen_pts.insert(gen_pts.size(), pt);
    end
  endfunction

  function automatic point_vec_t pick_query();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return any_stored();
    end
    if (r < 60) begin
      return jitter(any_stored());
    end
    if (r < 75) begin
      return near_origin_point();
    end
    return rand_point();
  endfunction

  function automatic point_vec_t pick_append();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20 && gen_pts.size() > 0) begin
      return any_stored();
    end
    if (r < 45) begin
      return near_origin_point();
    end
    return rand_point();
  endfunction

  function automatic void random_episode(bit fill);
    int n_app;
    int n_qry;
    int r;
    r = $urandom_range(0, 99);
    if (fill) begin
      n_app = nns_pkg::STORE_DEPTH + 2;
    end else if (r < 8) begin
      n_app = 0;
    end else if (r < 18) begin
      n_app = $urandom_range(13, 60);
    end else begin
      n_app = $urandom_range(1, 12);
    end
    if (fill || $urandom_range(0, 99) < 80) begin
      queue_request(nns_pkg::OP_CLEAR, rand_point(), $urandom_range(0, 99) < 30);
    end
    for (int i = 0; i < n_app; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        queue_request(OP_RESERVED, rand_point(), 1'b0);
      end
      if ($urandom_range(0, 99) < 10) begin
        queue_request(nns_pkg::OP_QUERY, pick_query(), 1'b0);
      end
      queue_request(nns_pkg::OP_APPEND, pick_append(), 1'b0);
    end
    if (fill) begin
      queue_request(nns_pkg::OP_QUERY, gen_pts[nns_pkg::STORE_DEPTH-1], 1'b0);
      queue_request(nns_pkg::OP_QUERY, gen_pts[0], 1'b0);
    end
    n_qry = $urandom_range(1, 6);
    for (int i = 0; i < n_qry; i++) begin
      queue_request(nns_pkg::OP_QUERY, pick_query(), 1'b0);
    end
  endfunction

  initial begin
    point_vec_t mixed;
    cycle_n      = 0;
    quiet_cycles = 0;
    bank_count   = 0;
    bank_peak    = 0;
    n_items      = 0;
    n_accepted   = 0;
    n_results    = 0;
    n_queries    = 0;
    n_mismatch   = 0;

    // Directed part: empty set, reserved operation, extreme coordinates,
    // ties and the largest possible distance.
    for (int k = 0; k < nns_pkg::MAX_DIMS; k++) begin
      mixed[k] = k[0] ? COORD_MAX : COORD_MIN;
    end
    queue_request(nns_pkg::OP_QUERY, flat_point(16'h0000), 1'b0);
    queue_request(OP_RESERVED, flat_point(16'hffff), 1'b0);
    queue_request(nns_pkg::OP_APPEND, flat_point(COORD_MAX), 1'b0);
    queue_request(nns_pkg::OP_APPEND, flat_point(COORD_MIN), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(COORD_MAX), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(COORD_MIN), 1'b0);
    queue_request(nns_pkg::OP_APPEND, flat_point(16'h8001), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(16'h0000), 1'b0);
    queue_request(nns_pkg::OP_APPEND, flat_point(COORD_MAX), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(COORD_MAX), 1'b0);
    queue_request(OP_RESERVED, flat_point(COORD_MIN), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(16'h0100), 1'b0);
    queue_request(nns_pkg::OP_CLEAR, flat_point(16'hffff), 1'b1);
    queue_request(nns_pkg::OP_QUERY, flat_point(16'h0000), 1'b0);
    queue_request(nns_pkg::OP_APPEND, flat_point(COORD_MIN), 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(COORD_MAX), 1'b0);
    queue_request(nns_pkg::OP_CLEAR, flat_point(16'h0000), 1'b0);
    queue_request(nns_pkg::OP_APPEND, mixed, 1'b0);
    queue_request(nns_pkg::OP_QUERY, ~mixed, 1'b0);
    queue_request(nns_pkg::OP_APPEND, ~mixed, 1'b0);
    queue_request(nns_pkg::OP_QUERY, flat_point(16'h0000), 1'b1);

    random_episode(1'b1);
    while (n_items < ITEM_TARGET) begin
      random_episode($urandom_range(0, 99) == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == n_items);
    wait (expect_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests with %0d queries; the store held up to %0d points.",
             n_accepted, n_queries, bank_peak);
    $display("Checked %0d results, %0d field mismatches, %0d results missing.",
             n_results, n_mismatch, expect_q.size());
    if (n_mismatch == 0 && expect_q.size() == 0) begin
      $display("PASS nearest_neighbour_search");
    end else begin
      $display("FAIL nearest_neighbour_search");
    end
    $finish;
  end

endmodule

`default_nettype wire
